FILE: rtl/core/rdft_pkg.sv
// shared types, register indexes and widths for the depth fog tint block
package rdft_pkg;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_FOG_CONTRAST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_RED      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_GREEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_BLUE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 3'd5;

    // reset value of the level count register
    localparam logic [4:0] LEVEL_COUNT_RESET = 5'd16;

    // magnitude of contrast * level fits in 22 bits, factor carries a sign on top
    localparam int NUM_W    = 22;
    localparam int FACTOR_W = NUM_W + 1;
    localparam int CNT_W    = $clog2(NUM_W + 1);

    // colour constants
    localparam logic [7:0]  BLUE_FLOOR = 8'd8;
    localparam logic [7:0]  CHAN_MAX   = 8'hff;
    localparam logic [15:0] FLAG_MASK  = 16'h8000;

    typedef struct packed {
        logic signed [18:0] fog_contrast;
        logic [7:0]         fog_red;
        logic [7:0]         fog_green;
        logic [7:0]         fog_blue;
        logic [3:0]         depth_level;
        logic [4:0]         level_count;
    } t_fog_cfg;

    typedef struct packed {
        logic [15:0] pixel_in;
        logic        last_in;
    } t_pix_in;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        last_out;
    } t_pix_out;

endpackage

FILE: rtl/core/rdft_factor_div.sv
// scaled fog factor: contrast * level / (count - 1), divisor at least one, one quotient bit per cycle
module rdft_factor_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  rdft_pkg::t_fog_cfg                   i_cfg,
    output logic                                 o_busy,
    output logic signed [rdft_pkg::FACTOR_W-1:0] o_factor
);

    logic                              r_busy;
    logic [rdft_pkg::CNT_W-1:0]        r_cnt;
    logic [rdft_pkg::NUM_W-1:0]        r_quo;
    logic [4:0]                        r_rem;
    logic [4:0]                        r_div;
    logic                              r_neg;
    logic signed [rdft_pkg::FACTOR_W-1:0] r_factor;

    logic signed [23:0]                num;
    logic [23:0]                       num_mag;
    logic [4:0]                        div_load;
    logic [5:0]                        rem_sh;
    logic                              ge;
    logic [4:0]                        n_rem;
    logic [rdft_pkg::NUM_W-1:0]        n_quo;
    logic [rdft_pkg::FACTOR_W-1:0]     quo_ext;

    // numerator and clamped divisor from the registers
    always_comb begin
        num      = 24'(i_cfg.fog_contrast * $signed({1'b0, i_cfg.depth_level}));
        num_mag  = num[23] ? 24'(-num) : num;
        div_load = (i_cfg.level_count < 5'd2) ? 5'd1 : 5'(i_cfg.level_count - 5'd1);
    end

    // one restoring step
    always_comb begin
        rem_sh  = {r_rem, r_quo[rdft_pkg::NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        n_rem   = ge ? 5'(rem_sh - {1'b0, r_div}) : rem_sh[4:0];
        n_quo   = {r_quo[rdft_pkg::NUM_W-2:0], ge};
        quo_ext = {1'b0, n_quo};
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_factor <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= rdft_pkg::CNT_W'(rdft_pkg::NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == rdft_pkg::CNT_W'(1)) begin
                r_busy   <= 1'b0;
                r_factor <= r_neg ? $signed(-quo_ext) : $signed(quo_ext);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= num_mag[rdft_pkg::NUM_W-1:0];
            r_rem <= '0;
            r_div <= div_load;
            r_neg <= num[23];
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy   = r_busy;
    assign o_factor = r_factor;

endmodule

FILE: rtl/core/rdft_tint.sv
// one colour channel pulled toward the fog colour and clamped to 8 bits
module rdft_tint (
    input  logic [7:0]                           i_chan,
    input  logic [7:0]                           i_fog,
    input  logic signed [rdft_pkg::FACTOR_W-1:0] i_factor,
    output logic [7:0]                           o_chan
);

    logic signed [8:0]  diff;
    logic signed [31:0] prod;
    logic signed [15:0] shifted;
    logic signed [17:0] t;

    always_comb begin
        diff    = $signed({1'b0, i_chan}) - $signed({1'b0, i_fog});
        prod    = 32'(diff * i_factor);
        // arithmetic shift right by 16 (floor)
        shifted = prod[31:16];
        t       = $signed({10'd0, i_chan}) - 18'(shifted);
        if (t < 0) begin
            o_chan = 8'd0;
        end else if (t > $signed({10'd0, rdft_pkg::CHAN_MAX})) begin
            o_chan = rdft_pkg::CHAN_MAX;
        end else begin
            o_chan = t[7:0];
        end
    end

endmodule

FILE: rtl/core/rgb555_depth_fog_tint.sv
// top level of the 1-5-5-5 palette fog tint block
// a beat passes the input register and then the result register on its way to the output
// throughput: one beat per cycle while the output is taken and no config write or divider run holds ready low
// o_ready is low while a config beat is offered, while its start strobe is pending and during the divider's 22 steps
// synchronous active-low reset clears valids and loads the register reset values
// ready is held low only by a stalled output, a config beat, its start strobe and the divider run after it
module rgb555_depth_fog_tint (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  rdft_pkg::t_pix_in                  i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output rdft_pkg::t_pix_out                 o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rdft_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rdft_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    rdft_pkg::t_fog_cfg  r_cfg;
    logic                r_start;
    logic                r_s1_valid;
    rdft_pkg::t_pix_in   r_s1;
    logic                r_out_valid;
    rdft_pkg::t_pix_out  r_out;

    logic                cfg_wr;
    logic                div_busy;
    logic signed [rdft_pkg::FACTOR_W-1:0] factor;
    logic                out_free;
    logic                s1_free;
    logic                in_acc;
    logic [7:0]          red_c, grn_c, blu_c;
    logic [7:0]          red_t, grn_t, blu_t;
    logic [7:0]          blu_f;
    rdft_pkg::t_pix_out  n_out;

    // config register writes
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fog_contrast <= '0;
            r_cfg.fog_red      <= '0;
            r_cfg.fog_green    <= '0;
            r_cfg.fog_blue     <= '0;
            r_cfg.depth_level  <= '0;
            r_cfg.level_count  <= rdft_pkg::LEVEL_COUNT_RESET;
            r_start            <= 1'b0;
        end else begin
            r_start <= cfg_wr;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    rdft_pkg::REG_FOG_CONTRAST: r_cfg.fog_contrast <= $signed(i_cfg_data);
                    rdft_pkg::REG_FOG_RED:      r_cfg.fog_red      <= i_cfg_data[7:0];
                    rdft_pkg::REG_FOG_GREEN:    r_cfg.fog_green    <= i_cfg_data[7:0];
                    rdft_pkg::REG_FOG_BLUE:     r_cfg.fog_blue     <= i_cfg_data[7:0];
                    rdft_pkg::REG_DEPTH_LEVEL:  r_cfg.depth_level  <= i_cfg_data[3:0];
                    rdft_pkg::REG_LEVEL_COUNT:  r_cfg.level_count  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    // factor divider
    rdft_factor_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_cfg    (r_cfg),
        .o_busy   (div_busy),
        .o_factor (factor)
    );

    // pipeline flow control
    assign out_free = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_ready  = s1_free && !div_busy && !r_start && !i_cfg_valid;
    assign in_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= in_acc;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_data;
        end
    end

    // expand channels to 8 bits
    assign red_c = {r_s1.pixel_in[4:0], 3'b000};
    assign grn_c = {r_s1.pixel_in[9:5], 3'b000};
    assign blu_c = {r_s1.pixel_in[14:10], 3'b000};

    rdft_tint u_tint_r (
        .i_chan(red_c), .i_fog(r_cfg.fog_red),   .i_factor(factor), .o_chan(red_t)
    );
    rdft_tint u_tint_g (
        .i_chan(grn_c), .i_fog(r_cfg.fog_green), .i_factor(factor), .o_chan(grn_t)
    );
    rdft_tint u_tint_b (
        .i_chan(blu_c), .i_fog(r_cfg.fog_blue),  .i_factor(factor), .o_chan(blu_t)
    );

    // blue floor, narrowing, zero entry passes through
    always_comb begin
        blu_f          = (blu_t < rdft_pkg::BLUE_FLOOR) ? rdft_pkg::BLUE_FLOOR : blu_t;
        n_out.last_out = r_s1.last_in;
        if (r_s1.pixel_in == 16'd0) begin
            n_out.pixel_out = 16'd0;
        end else begin
            n_out.pixel_out = (r_s1.pixel_in & rdft_pkg::FLAG_MASK)
                            | {1'b0, blu_f[7:3], grn_t[7:3], red_t[7:3]};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: rtl/core/rdft_checker.sv
// port-level checks for the fog tint block, bound to the top level
module rdft_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input rdft_pkg::t_pix_out o_data,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // the factor is recomputed after a write, so input stays blocked
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_ready)
        else $error("input ready while factor is recomputed");

    // blue never falls below the floor on a tinted entry
    a_blue_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.pixel_out != 16'd0) |-> o_data.pixel_out[14:10] != 5'd0)
        else $error("blue channel below floor");

endmodule

bind rgb555_depth_fog_tint rdft_checker u_rdft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_data      (o_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

FILE: tb/sv/testbench.sv
// self-checking testbench for the 1-5-5-5 palette fog tint block
`timescale 1ns / 1ps

module testbench;

    // spare config index with no register behind it
    localparam logic [rdft_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASES = 10;
    localparam int BEATS_PER_PHASE = 100;
    localparam int MAX_REPORTS = 200;

    typedef enum logic {ROW_WRITE, ROW_BEAT} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [rdft_pkg::CFG_IDX_W-1:0]  idx;
        logic [rdft_pkg::CFG_DATA_W-1:0] word;
        rdft_pkg::t_pix_in               beat;
        bit                              typed;
        logic [15:0]                     want;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    rdft_pkg::t_pix_in               i_data = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    rdft_pkg::t_pix_out              o_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rdft_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rdft_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of the registers and results still owed by the block
    rdft_pkg::t_fog_cfg  fog_regs;
    rdft_pkg::t_pix_out  pending_tints[$];
    rdft_pkg::t_pix_out  due_tint;
    t_dir_row            dir_rows[$];
    int                  fail_count = 0;
    int                  tx_gap_pct = 0;
    int                  rx_gap_pct = 0;
    bit                  hold_ask = 1'b0;
    int                  hold_left = 0;

    rgb555_depth_fog_tint dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // watchdog
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // one 8-bit channel pulled toward the fog colour, clamped to a byte
    function automatic logic [7:0] shade(logic [7:0] chan, logic [7:0] fog, longint factor);
        longint t;
        t = longint'(chan) - (((longint'(chan) - longint'(fog)) * factor) >>> 16);
        if (t < 0)
            t = 0;
        if (t > longint'(rdft_pkg::CHAN_MAX))
            t = longint'(rdft_pkg::CHAN_MAX);
        return t[7:0];
    endfunction

    // expected tinted entry for one input beat under the current registers
    function automatic rdft_pkg::t_pix_out fog_tint(rdft_pkg::t_pix_in beat);
        rdft_pkg::t_pix_out res;
        longint             num;
        longint             div;
        longint             mag;
        longint             factor;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        res.last_out = beat.last_in;
        res.pixel_out = '0;
        if (beat.pixel_in != '0) begin
            num = longint'($signed(fog_regs.fog_contrast))
                * longint'(fog_regs.depth_level);
            div = longint'(fog_regs.level_count) - 1;
            // divisor below one is taken as one
            if (div < 1)
                div = 1;
            mag = (num < 0 ? -num : num) / div;
            factor = (num < 0) ? -mag : mag;
            r = shade({beat.pixel_in[4:0], 3'b000}, fog_regs.fog_red, factor);
            g = shade({beat.pixel_in[9:5], 3'b000}, fog_regs.fog_green, factor);
            b = shade({beat.pixel_in[14:10], 3'b000}, fog_regs.fog_blue, factor);
            if (b < rdft_pkg::BLUE_FLOOR)
                b = rdft_pkg::BLUE_FLOOR;
            res.pixel_out = (beat.pixel_in & rdft_pkg::FLAG_MASK)
                          | {1'b0, b[7:3], g[7:3], r[7:3]};
        end
        return res;
    endfunction

    function automatic void apply_reg(logic [rdft_pkg::CFG_IDX_W-1:0] idx,
                                      logic [rdft_pkg::CFG_DATA_W-1:0] word);
        case (idx)
            rdft_pkg::REG_FOG_CONTRAST: fog_regs.fog_contrast = word[18:0];
            rdft_pkg::REG_FOG_RED:      fog_regs.fog_red = word[7:0];
            rdft_pkg::REG_FOG_GREEN:    fog_regs.fog_green = word[7:0];
            rdft_pkg::REG_FOG_BLUE:     fog_regs.fog_blue = word[7:0];
            rdft_pkg::REG_DEPTH_LEVEL:  fog_regs.depth_level = word[3:0];
            rdft_pkg::REG_LEVEL_COUNT:  fog_regs.level_count = word[4:0];
            default: ;
        endcase
    endfunction

    function automatic t_dir_row write_row(logic [rdft_pkg::CFG_IDX_W-1:0] idx,
                                           logic [rdft_pkg::CFG_DATA_W-1:0] word);
        t_dir_row row;
        row = '{ROW_WRITE, idx, word, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic t_dir_row beat_row(logic [15:0] px, logic last, bit typed,
                                          logic [15:0] want);
        t_dir_row row;
        row = '{ROW_BEAT, '0, '0, '{px, last}, typed, want};
        return row;
    endfunction

    // result side ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_gap_pct);
        end
    end

    // compare each result beat with the oldest owed tint
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tints.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("unexpected result beat pixel_out %h last_out %b",
                           o_data.pixel_out, o_data.last_out);
            end else begin
                due_tint = pending_tints.pop_front();
                if (o_data.pixel_out !== due_tint.pixel_out) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("pixel_out expected %h actual %h",
                               due_tint.pixel_out, o_data.pixel_out);
                end
                if (o_data.last_out !== due_tint.last_out) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("last_out expected %b actual %b",
                               due_tint.last_out, o_data.last_out);
                end
            end
        end
    end

    // config beat; valid is left high so back-to-back writes need no gap
    task automatic write_reg(logic [rdft_pkg::CFG_IDX_W-1:0] idx,
                             logic [rdft_pkg::CFG_DATA_W-1:0] word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, word);
    endtask

    // register value, with random junk above its width on about half the writes
    task automatic write_field(logic [rdft_pkg::CFG_IDX_W-1:0] idx, int unsigned value,
                               int width);
        logic [rdft_pkg::CFG_DATA_W-1:0] mask;
        logic [rdft_pkg::CFG_DATA_W-1:0] noise;
        mask = rdft_pkg::CFG_DATA_W'((64'd1 << width) - 1);
        noise = $urandom_range(1) ? rdft_pkg::CFG_DATA_W'($urandom) : '0;
        write_reg(idx, (noise & ~mask) | (rdft_pkg::CFG_DATA_W'(value) & mask));
    endtask

    task automatic send_beat(rdft_pkg::t_pix_in beat, bit typed, logic [15:0] want);
        rdft_pkg::t_pix_out due;
        if (i_cfg_valid)
            i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= beat;
        do @(posedge i_clk); while (!o_ready);
        due = fog_tint(beat);
        if (typed)
            due.pixel_out = want;
        pending_tints.push_back(due);
    endtask

    // stop offering beats until every owed tint has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_tints.size() != 0);
    endtask

    task automatic set_pace(int tx_pct, int rx_pct);
        tx_gap_pct = tx_pct;
        rx_gap_pct = rx_pct;
    endtask

    // random register set, extremes weighted in
    task automatic random_regs();
        logic [rdft_pkg::CFG_DATA_W-1:0] contrast;
        int unsigned                     count;
        int unsigned                     level;
        case ($urandom_range(7))
            0: contrast = 19'h40000;
            1: contrast = 19'h3ffff;
            2: contrast = 19'h00000;
            3: contrast = 19'h10000;
            4: contrast = 19'h70000;
            default: contrast = rdft_pkg::CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(9))
            0: count = 0;
            1: count = 1;
            2: count = 31;
            3: count = 2;
            4: count = 16;
            default: count = $urandom_range(16, 2);
        endcase
        if ($urandom_range(3) == 0)
            level = $urandom_range(1) ? 15 : 0;
        else
            level = $urandom_range(15);
        write_reg(rdft_pkg::REG_FOG_CONTRAST, contrast);
        write_field(rdft_pkg::REG_FOG_RED,
                    $urandom_range(3) == 0 ? 0 : $urandom_range(255), 8);
        write_field(rdft_pkg::REG_FOG_GREEN,
                    $urandom_range(3) == 0 ? 255 : $urandom_range(255), 8);
        write_field(rdft_pkg::REG_FOG_BLUE, $urandom_range(255), 8);
        write_field(rdft_pkg::REG_DEPTH_LEVEL, level, 4);
        write_field(rdft_pkg::REG_LEVEL_COUNT, count, 5);
    endtask

    initial begin
        rdft_pkg::t_pix_in beat;
        bit                prev_beat;
        fog_regs = '0;
        fog_regs.level_count = rdft_pkg::LEVEL_COUNT_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; typed results only where obvious
        // registers at reset give a zero factor: entries pass with blue floored
        dir_rows.push_back(beat_row(16'h0000, 1'b0, 1'b1, 16'h0000));
        dir_rows.push_back(beat_row(16'h7fff, 1'b1, 1'b1, 16'h7fff));
        dir_rows.push_back(beat_row(16'hffff, 1'b0, 1'b1, 16'hffff));
        dir_rows.push_back(beat_row(16'h8000, 1'b1, 1'b1, 16'h8400));
        dir_rows.push_back(beat_row(16'h0001, 1'b0, 1'b1, 16'h0401));
        // unit factor: every channel lands on the fog colour, blue then floored
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_CONTRAST, 19'h10000));
        dir_rows.push_back(write_row(rdft_pkg::REG_DEPTH_LEVEL, 19'd15));
        dir_rows.push_back(write_row(rdft_pkg::REG_LEVEL_COUNT, 19'd16));
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_RED, 19'hff));
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_GREEN, 19'h00));
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_BLUE, 19'h00));
        dir_rows.push_back(beat_row(16'h7fff, 1'b1, 1'b1, 16'h041f));
        dir_rows.push_back(beat_row(16'h8001, 1'b0, 1'b1, 16'h841f));
        dir_rows.push_back(beat_row(16'h0000, 1'b1, 1'b1, 16'h0000));
        // most negative contrast with a level count of one, then zero
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_CONTRAST, 19'h40000));
        dir_rows.push_back(write_row(rdft_pkg::REG_LEVEL_COUNT, 19'd1));
        dir_rows.push_back(beat_row(16'h7c1f, 1'b0, 1'b0, '0));
        dir_rows.push_back(beat_row(16'h03e0, 1'b1, 1'b0, '0));
        dir_rows.push_back(write_row(rdft_pkg::REG_LEVEL_COUNT, 19'd0));
        dir_rows.push_back(beat_row(16'h5555, 1'b0, 1'b0, '0));
        // largest contrast at level zero still gives a zero factor
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_CONTRAST, 19'h3ffff));
        dir_rows.push_back(write_row(rdft_pkg::REG_LEVEL_COUNT, 19'd31));
        dir_rows.push_back(write_row(rdft_pkg::REG_DEPTH_LEVEL, 19'd0));
        dir_rows.push_back(beat_row(16'h2a4a, 1'b1, 1'b1, 16'h2a4a));
        dir_rows.push_back(write_row(rdft_pkg::REG_DEPTH_LEVEL, 19'd15));
        dir_rows.push_back(beat_row(16'hffff, 1'b0, 1'b0, '0));
        dir_rows.push_back(beat_row(16'h8000, 1'b1, 1'b0, '0));
        // write to the spare index must leave the registers alone
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_RED, 19'h00));
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_GREEN, 19'hff));
        dir_rows.push_back(write_row(rdft_pkg::REG_FOG_BLUE, 19'hff));
        dir_rows.push_back(write_row(REG_SPARE, 19'h7ffff));
        dir_rows.push_back(beat_row(16'h1234, 1'b0, 1'b0, '0));
        dir_rows.push_back(beat_row(16'h0000, 1'b0, 1'b1, 16'h0000));

        set_pace(14, 72);
        prev_beat = 1'b0;
        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_WRITE) begin
                if (prev_beat)
                    drain();
                write_reg(dir_rows[n].idx, dir_rows[n].word);
                prev_beat = 1'b0;
            end else begin
                send_beat(dir_rows[n].beat, dir_rows[n].typed, dir_rows[n].want);
                prev_beat = 1'b1;
            end
        end

        // random phases, each under its own register set
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            random_regs();
            if (phase < 4)
                set_pace(14, 72);
            else if (phase < 7)
                set_pace(72, 14);
            else
                set_pace(0, 0);
            // long result stall while beats keep coming
            if (phase == 8)
                hold_ask = 1'b1;
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                case ($urandom_range(31))
                    0, 1: beat.pixel_in = 16'h0000;
                    2:    beat.pixel_in = rdft_pkg::FLAG_MASK;
                    3:    beat.pixel_in = 16'hffff;
                    default: beat.pixel_in = 16'($urandom);
                endcase
                beat.last_in = ($urandom_range(7) == 0);
                // sender pauses until everything has come back
                if (phase == 3 && k == BEATS_PER_PHASE / 2)
                    drain();
                send_beat(beat, 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_tints.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rdft_pkg.sv
rtl/core/rdft_factor_div.sv
rtl/core/rdft_tint.sv
rtl/core/rgb555_depth_fog_tint.sv
rtl/core/rdft_checker.sv
tb/sv/testbench.sv
